@@ rtl/cannonball_drag_force_assert.svh @@
// Assertion macros for the cannonball drag force block.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef CANNONBALL_DRAG_FORCE_ASSERT_SVH
`define CANNONBALL_DRAG_FORCE_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define CDF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define CDF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/cdf_pkg.sv @@
// Shared types, constants and the step table of the cannonball drag force block.
// No dependencies; used by cdf_mul and cannonball_drag_force.
package cdf_pkg;

	localparam int IN_W     = 384;
	localparam int OUT_W    = 384;
	localparam int USER_W   = 1;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int WORD_W   = 64;
	localparam int PROD_W   = 128;
	localparam int HALF_W   = 32;
	localparam int DIV_BITS = 93;
	localparam int SQRT_STEPS = 32;

	localparam logic signed [63:0] QONE   = 64'sh0000_0000_2000_0000;
	localparam logic signed [63:0] QONE30 = 64'sh0000_0000_4000_0000;
	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	localparam logic [2:0] REG_DRAG_COEFF = 3'd0;
	localparam logic [2:0] REG_AREA       = 3'd1;
	localparam logic [2:0] REG_OFFSET_X   = 3'd2;
	localparam logic [2:0] REG_OFFSET_Y   = 3'd3;
	localparam logic [2:0] REG_OFFSET_Z   = 3'd4;

	localparam logic [5:0] STEP_PRE_DIV  = 6'd10;
	localparam logic [5:0] STEP_PRE_SQRT = 6'd22;
	localparam logic [5:0] STEP_LAST     = 6'd35;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL_ISSUE, ST_MUL_WAIT, ST_ACC, ST_WB,
		ST_DIV_LOAD, ST_DIV_RUN, ST_DIV_WB, ST_SQRT, ST_CHECK, ST_FINISH
	} state_t;

	typedef enum logic [5:0] {
		OP_S1, OP_S2, OP_S3, OP_R0, OP_R1, OP_R2, OP_M, OP_D,
		OP_C00, OP_C01, OP_C02, OP_C10, OP_C11, OP_C12, OP_C20, OP_C21, OP_C22,
		OP_VB0, OP_VB1, OP_VB2, OP_NVB0, OP_NVB1, OP_NVB2,
		OP_HELD, OP_CORR, OP_DRAG, OP_AREA, OP_T1, OP_VMAG, OP_T2, OP_RHOE, OP_T3,
		OP_F0, OP_F1, OP_F2, OP_OFF0, OP_OFF1, OP_OFF2
	} opnd_t;

	typedef enum logic [4:0] {
		D_NONE, D_Q11, D_Q22, D_Q33, D_Q12, D_Q13, D_Q23, D_M2, D_DEN,
		D_QS1M, D_QS2M, D_QS3M, D_VB0, D_VB1, D_VB2, D_SUM, D_RHOE,
		D_T1, D_T2, D_T3, D_F0, D_F1, D_F2, D_TQ0, D_TQ1, D_TQ2
	} dest_t;

	typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} acc_mode_t;

	typedef enum logic [1:0] {WF_SAT64, WF_CLAMP32, WF_RAW} wfmt_t;

	typedef struct packed {
		opnd_t     a_sel;
		opnd_t     b_sel;
		acc_mode_t mode;
		logic      last;
		logic [5:0] shamt;
		wfmt_t     fmt;
		dest_t     dest;
	} step_ctl_t;

	function automatic logic signed [63:0] sext32(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic step_ctl_t mk(input opnd_t a, input opnd_t b, input acc_mode_t md,
			input logic lst, input logic [5:0] sh, input wfmt_t f, input dest_t d);
		step_ctl_t c;
		c.a_sel = a;
		c.b_sel = b;
		c.mode  = md;
		c.last  = lst;
		c.shamt = sh;
		c.fmt   = f;
		c.dest  = d;
		return c;
	endfunction

	// One multiply per step; the last step of a group rounds and stores.
	function automatic step_ctl_t step_decode(input logic [5:0] step);
		step_ctl_t c;
		unique case (step)
			6'd0:  c = mk(OP_S1, OP_S1, ACC_LOAD, 1'b1, 6'd29, WF_SAT64, D_Q11);
			6'd1:  c = mk(OP_S2, OP_S2, ACC_LOAD, 1'b1, 6'd29, WF_SAT64, D_Q22);
			6'd2:  c = mk(OP_S3, OP_S3, ACC_LOAD, 1'b1, 6'd29, WF_SAT64, D_Q33);
			6'd3:  c = mk(OP_S1, OP_S2, ACC_LOAD, 1'b1, 6'd29, WF_SAT64, D_Q12);
			6'd4:  c = mk(OP_S1, OP_S3, ACC_LOAD, 1'b1, 6'd29, WF_SAT64, D_Q13);
			6'd5:  c = mk(OP_S2, OP_S3, ACC_LOAD, 1'b1, 6'd29, WF_SAT64, D_Q23);
			6'd6:  c = mk(OP_M,  OP_M,  ACC_LOAD, 1'b1, 6'd29, WF_SAT64, D_M2);
			6'd7:  c = mk(OP_D,  OP_D,  ACC_LOAD, 1'b1, 6'd29, WF_SAT64, D_DEN);
			6'd8:  c = mk(OP_S1, OP_M,  ACC_LOAD, 1'b1, 6'd29, WF_SAT64, D_QS1M);
			6'd9:  c = mk(OP_S2, OP_M,  ACC_LOAD, 1'b1, 6'd29, WF_SAT64, D_QS2M);
			6'd10: c = mk(OP_S3, OP_M,  ACC_LOAD, 1'b1, 6'd29, WF_SAT64, D_QS3M);
			6'd11: c = mk(OP_C00, OP_R0, ACC_LOAD, 1'b0, 6'd0, WF_SAT64, D_NONE);
			6'd12: c = mk(OP_C01, OP_R1, ACC_ADD,  1'b0, 6'd0, WF_SAT64, D_NONE);
			6'd13: c = mk(OP_C02, OP_R2, ACC_ADD,  1'b1, 6'd29, WF_CLAMP32, D_VB0);
			6'd14: c = mk(OP_C10, OP_R0, ACC_LOAD, 1'b0, 6'd0, WF_SAT64, D_NONE);
			6'd15: c = mk(OP_C11, OP_R1, ACC_ADD,  1'b0, 6'd0, WF_SAT64, D_NONE);
			6'd16: c = mk(OP_C12, OP_R2, ACC_ADD,  1'b1, 6'd29, WF_CLAMP32, D_VB1);
			6'd17: c = mk(OP_C20, OP_R0, ACC_LOAD, 1'b0, 6'd0, WF_SAT64, D_NONE);
			6'd18: c = mk(OP_C21, OP_R1, ACC_ADD,  1'b0, 6'd0, WF_SAT64, D_NONE);
			6'd19: c = mk(OP_C22, OP_R2, ACC_ADD,  1'b1, 6'd29, WF_CLAMP32, D_VB2);
			6'd20: c = mk(OP_VB0, OP_VB0, ACC_LOAD, 1'b0, 6'd0, WF_SAT64, D_NONE);
			6'd21: c = mk(OP_VB1, OP_VB1, ACC_ADD,  1'b0, 6'd0, WF_SAT64, D_NONE);
			6'd22: c = mk(OP_VB2, OP_VB2, ACC_ADD,  1'b1, 6'd0, WF_RAW, D_SUM);
			6'd23: c = mk(OP_HELD, OP_CORR, ACC_LOAD, 1'b1, 6'd30, WF_SAT64, D_RHOE);
			6'd24: c = mk(OP_DRAG, OP_AREA, ACC_LOAD, 1'b1, 6'd0, WF_SAT64, D_T1);
			6'd25: c = mk(OP_T1, OP_VMAG, ACC_LOAD, 1'b1, 6'd24, WF_SAT64, D_T2);
			6'd26: c = mk(OP_T2, OP_RHOE, ACC_LOAD, 1'b1, 6'd24, WF_SAT64, D_T3);
			6'd27: c = mk(OP_T3, OP_NVB0, ACC_LOAD, 1'b1, 6'd32, WF_SAT64, D_F0);
			6'd28: c = mk(OP_T3, OP_NVB1, ACC_LOAD, 1'b1, 6'd32, WF_SAT64, D_F1);
			6'd29: c = mk(OP_T3, OP_NVB2, ACC_LOAD, 1'b1, 6'd32, WF_SAT64, D_F2);
			6'd30: c = mk(OP_OFF1, OP_F2, ACC_LOAD, 1'b0, 6'd0, WF_SAT64, D_NONE);
			6'd31: c = mk(OP_OFF2, OP_F1, ACC_SUB,  1'b1, 6'd16, WF_SAT64, D_TQ0);
			6'd32: c = mk(OP_OFF2, OP_F0, ACC_LOAD, 1'b0, 6'd0, WF_SAT64, D_NONE);
			6'd33: c = mk(OP_OFF0, OP_F2, ACC_SUB,  1'b1, 6'd16, WF_SAT64, D_TQ1);
			6'd34: c = mk(OP_OFF0, OP_F1, ACC_LOAD, 1'b0, 6'd0, WF_SAT64, D_NONE);
			6'd35: c = mk(OP_OFF1, OP_F0, ACC_SUB,  1'b1, 6'd16, WF_SAT64, D_TQ2);
			default: c = mk(OP_S1, OP_S1, ACC_LOAD, 1'b0, 6'd0, WF_SAT64, D_NONE);
		endcase
		return c;
	endfunction

endpackage

@@ rtl/cdf_mul.sv @@
// Shared signed 64x64 multiplier built from four 32x32 partial products.
// Depends on cdf_pkg for word widths.
module cdf_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [cdf_pkg::WORD_W-1:0]   a,
	input  logic signed [cdf_pkg::WORD_W-1:0]   b,
	output logic                                done,
	output logic signed [cdf_pkg::PROD_W-1:0]   prod
);
	import cdf_pkg::*;

	localparam logic [2:0] CNT_PP_END = 3'd4;
	localparam logic [2:0] CNT_LAST   = 3'd5;

	logic [WORD_W-1:0]  ua_q, ub_q;
	logic               neg_q;
	logic               busy_q, done_q;
	logic [2:0]         cnt_q;
	logic [WORD_W-1:0]  pp_q;
	logic [1:0]         ppsh_q;
	logic [PROD_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_q;

	logic [HALF_W-1:0]  pa, pb;
	logic [1:0]         psh;

	// Pick the halves for the current partial product.
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				pa = ua_q[HALF_W-1:0];      pb = ub_q[HALF_W-1:0];      psh = 2'd0;
			end
			2'd1: begin
				pa = ua_q[HALF_W-1:0];      pb = ub_q[WORD_W-1:HALF_W]; psh = 2'd1;
			end
			2'd2: begin
				pa = ua_q[WORD_W-1:HALF_W]; pb = ub_q[HALF_W-1:0];      psh = 2'd1;
			end
			default: begin
				pa = ua_q[WORD_W-1:HALF_W]; pb = ub_q[WORD_W-1:HALF_W]; psh = 2'd2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= a[WORD_W-1] ? WORD_W'(-a) : a;
			ub_q  <= b[WORD_W-1] ? WORD_W'(-b) : b;
			neg_q <= a[WORD_W-1] ^ b[WORD_W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < CNT_PP_END) begin
				pp_q   <= pa * pb;
				ppsh_q <= psh;
			end
			if (cnt_q != 3'd0 && cnt_q <= CNT_PP_END) begin
				acc_q <= acc_q + ({{WORD_W{1'b0}}, pp_q} << {ppsh_q, 5'b0});
			end
			if (cnt_q == CNT_LAST) begin
				prod_q <= neg_q ? -$signed(acc_q) : $signed(acc_q);
			end
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

@@ rtl/cannonball_drag_force.sv @@
// Cannonball drag force and torque engine: top level with sequencer and datapath.
// Depends on cdf_pkg, cdf_mul and cannonball_drag_force_assert.svh.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser. One input word is one
//   state sample: attitude MRP, velocity, wind, density sample and correction;
//   s_tuser[0] marks the density sample as fresh, which loads the held density.
//   One output word per input word leaves on m_tvalid/m_tready/m_tdata: the
//   body-frame drag force and the drag torque about the body point, saturated.
//   Coefficient, area and pressure-center offset are written over the APB port
//   while the block is idle; pready is tied high and reads return the registers.
// Work per item and throughput:
//   An item runs through nine 93-step restoring divisions for the rotation
//   matrix, up to 36 multiplies on the shared four-pass 32x32 multiplier and the
//   32-step square root. s_tready is high only while the sequencer is idle, so
//   one item is in work at a time.
// Reset and stall:
//   Reset clears registers, the held density and the sequencer. A finished result
//   sits in the output register; if the receiver stalls, the next item can still
//   be accepted and computed, and the sequencer then holds until the output frees.
module cannonball_drag_force (
	input  logic                             clk,
	input  logic                             arst_n,
	// s_tdata, lowest bit up: mrp_1, mrp_2, mrp_3, vel_x, vel_y, vel_z,
	// wind_x, wind_y, wind_z, rho_sample(63), rho_corr, one pad bit
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [cdf_pkg::IN_W-1:0]         s_tdata,
	// s_tuser: rho_valid
	input  logic [cdf_pkg::USER_W-1:0]       s_tuser,
	// m_tdata, lowest bit up: force_x, force_y, force_z, torque_x, torque_y, torque_z
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [cdf_pkg::OUT_W-1:0]        m_tdata,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [cdf_pkg::ADDR_W-1:0]       paddr,
	input  logic [cdf_pkg::DATA_W-1:0]       pwdata,
	output logic [cdf_pkg::DATA_W-1:0]       prdata,
	output logic                             pready
);
	import cdf_pkg::*;

	// Sequencer
	state_t      state_q, state_d;
	logic [5:0]  step_q;
	step_ctl_t   ctl;

	// Configuration
	logic [15:0]        drag_q;
	logic [31:0]        area_q;
	logic signed [31:0] off_q [3];
	logic [2:0]         reg_idx;
	logic               cfg_wr;

	// Held density
	logic [62:0] held_q;

	// Captured item
	logic signed [31:0] mrp_q [3];
	logic signed [32:0] rel_q [3];
	logic signed [31:0] corr_q;

	// Intermediates
	logic signed [63:0] q11_q, q22_q, q33_q, q12_q, q13_q, q23_q;
	logic signed [63:0] m2_q, den_q, qs1m_q, qs2m_q, qs3m_q;
	logic signed [63:0] c_q [9];
	logic signed [31:0] vb_q [3];
	logic signed [63:0] rhoe_q, t1_q, t2_q, t3_q;
	logic signed [63:0] f_q [3];
	logic signed [63:0] tq_q [3];
	logic               zero_q;
	logic signed [63:0] p_w, m_w, d_w;

	// Multiply-accumulate
	logic                mul_start, mul_done;
	logic signed [63:0]  mul_a, mul_b;
	logic signed [127:0] mul_p;
	logic signed [127:0] acc_q;
	logic signed [127:0] wb_sh;
	logic signed [63:0]  wb_val;

	// Divider
	logic [3:0]         div_idx_q;
	logic [6:0]         div_cnt_q;
	logic [DIV_BITS-1:0] dvd_q;
	logic [63:0]        rem_q, quo_q;
	logic               dneg_q;
	logic signed [63:0] num_w;
	logic [63:0]        rsh_w;
	logic               dsub_w;
	logic [63:0]        qsat_w;

	// Square root
	logic [4:0]  sq_k_q;
	logic [63:0] sx_q, sres_q;
	logic [63:0] sbit_w, st_w;

	// Output register
	logic [OUT_W-1:0] out_q;
	logic             out_valid_q;
	logic             out_load;
	logic             s_accept;

	assign ctl      = step_decode(step_q);
	assign s_accept = s_tvalid && s_tready;

	//------------------------------------------------------------------
	// APB register file: write on the access phase, read at any time.
	//------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_q <= '0;
			area_q <= '0;
			off_q[0] <= '0;
			off_q[1] <= '0;
			off_q[2] <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_DRAG_COEFF: drag_q   <= pwdata[15:0];
				REG_AREA:       area_q   <= pwdata;
				REG_OFFSET_X:   off_q[0] <= pwdata;
				REG_OFFSET_Y:   off_q[1] <= pwdata;
				REG_OFFSET_Z:   off_q[2] <= pwdata;
				default: ;   // drop writes past the register list
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DRAG_COEFF: prdata = {16'b0, drag_q};
			REG_AREA:       prdata = area_q;
			REG_OFFSET_X:   prdata = off_q[0];
			REG_OFFSET_Y:   prdata = off_q[1];
			REG_OFFSET_Z:   prdata = off_q[2];
			default:        prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// Sequencer: next state
	//------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (s_accept) state_d = ST_MUL_ISSUE;
			ST_MUL_ISSUE: state_d = ST_MUL_WAIT;
			ST_MUL_WAIT:  if (mul_done) state_d = ST_ACC;
			ST_ACC:       state_d = ctl.last ? ST_WB : ST_MUL_ISSUE;
			ST_WB: begin
				if (step_q == STEP_PRE_DIV) state_d = ST_DIV_LOAD;
				else if (step_q == STEP_PRE_SQRT) state_d = ST_SQRT;
				else if (step_q == STEP_LAST) state_d = ST_FINISH;
				else state_d = ST_MUL_ISSUE;
			end
			ST_DIV_LOAD:  state_d = ST_DIV_RUN;
			ST_DIV_RUN:   if (div_cnt_q == 7'(DIV_BITS - 1)) state_d = ST_DIV_WB;
			ST_DIV_WB:    state_d = (div_idx_q == 4'd8) ? ST_MUL_ISSUE : ST_DIV_LOAD;
			ST_SQRT:      if (sq_k_q == 5'd0) state_d = ST_CHECK;
			ST_CHECK:     state_d = (sres_q == 64'd0) ? ST_FINISH : ST_MUL_ISSUE;
			ST_FINISH:    if (out_load) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	//------------------------------------------------------------------
	// Sequencer: outputs
	//------------------------------------------------------------------
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		mul_start = (state_q == ST_MUL_ISSUE);
		out_load  = (state_q == ST_FINISH) && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			div_idx_q <= '0;
			div_cnt_q <= '0;
			sq_k_q    <= '0;
			held_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_accept) begin
				step_q <= '0;
				if (s_tuser[0]) held_q <= s_tdata[350:288];
			end
			if ((state_q == ST_ACC && !ctl.last) || state_q == ST_WB) begin
				step_q <= step_q + 6'd1;
			end
			if (state_q == ST_WB && step_q == STEP_PRE_DIV) div_idx_q <= '0;
			if (state_q == ST_DIV_WB) div_idx_q <= div_idx_q + 4'd1;
			if (state_q == ST_DIV_LOAD) div_cnt_q <= '0;
			if (state_q == ST_DIV_RUN) div_cnt_q <= div_cnt_q + 7'd1;
			if (state_q == ST_WB && step_q == STEP_PRE_SQRT) sq_k_q <= 5'(SQRT_STEPS - 1);
			if (state_q == ST_SQRT) sq_k_q <= sq_k_q - 5'd1;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	//------------------------------------------------------------------
	// Capture the item; relative air velocity is exact in 33 bits.
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s_accept) begin
			mrp_q[0] <= s_tdata[31:0];
			mrp_q[1] <= s_tdata[63:32];
			mrp_q[2] <= s_tdata[95:64];
			rel_q[0] <= {s_tdata[127], s_tdata[127:96]}  - {s_tdata[223], s_tdata[223:192]};
			rel_q[1] <= {s_tdata[159], s_tdata[159:128]} - {s_tdata[255], s_tdata[255:224]};
			rel_q[2] <= {s_tdata[191], s_tdata[191:160]} - {s_tdata[287], s_tdata[287:256]};
			corr_q   <= s_tdata[382:351];
		end
	end

	//------------------------------------------------------------------
	// Operand select for the shared multiplier
	//------------------------------------------------------------------
	assign p_w = q11_q + q22_q + q33_q;
	assign m_w = QONE - p_w;
	assign d_w = QONE + p_w;

	function automatic logic signed [63:0] pick(input opnd_t sel);
		logic signed [63:0] v;
		case (sel)
			OP_S1:   v = sext32(mrp_q[0]);
			OP_S2:   v = sext32(mrp_q[1]);
			OP_S3:   v = sext32(mrp_q[2]);
			OP_R0:   v = {{31{rel_q[0][32]}}, rel_q[0]};
			OP_R1:   v = {{31{rel_q[1][32]}}, rel_q[1]};
			OP_R2:   v = {{31{rel_q[2][32]}}, rel_q[2]};
			OP_M:    v = m_w;
			OP_D:    v = d_w;
			OP_C00:  v = c_q[0];
			OP_C01:  v = c_q[1];
			OP_C02:  v = c_q[2];
			OP_C10:  v = c_q[3];
			OP_C11:  v = c_q[4];
			OP_C12:  v = c_q[5];
			OP_C20:  v = c_q[6];
			OP_C21:  v = c_q[7];
			OP_C22:  v = c_q[8];
			OP_VB0:  v = sext32(vb_q[0]);
			OP_VB1:  v = sext32(vb_q[1]);
			OP_VB2:  v = sext32(vb_q[2]);
			OP_NVB0: v = -sext32(vb_q[0]);
			OP_NVB1: v = -sext32(vb_q[1]);
			OP_NVB2: v = -sext32(vb_q[2]);
			OP_HELD: v = {1'b0, held_q};
			OP_CORR: v = sext32(corr_q) + QONE30;
			OP_DRAG: v = {48'b0, drag_q};
			OP_AREA: v = {32'b0, area_q};
			OP_T1:   v = t1_q;
			OP_VMAG: v = {32'b0, sres_q[31:0]};
			OP_T2:   v = t2_q;
			OP_RHOE: v = rhoe_q;
			OP_T3:   v = t3_q;
			OP_F0:   v = f_q[0];
			OP_F1:   v = f_q[1];
			OP_F2:   v = f_q[2];
			OP_OFF0: v = sext32(off_q[0]);
			OP_OFF1: v = sext32(off_q[1]);
			OP_OFF2: v = sext32(off_q[2]);
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		mul_a = pick(ctl.a_sel);
		mul_b = pick(ctl.b_sel);
	end

	cdf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	//------------------------------------------------------------------
	// Round toward minus infinity by arithmetic shift, then saturate unless raw.
	//------------------------------------------------------------------
	assign wb_sh = acc_q >>> ctl.shamt;

	always_comb begin
		case (ctl.fmt)
			WF_CLAMP32: begin
				if ((&wb_sh[127:31]) || !(|wb_sh[127:31])) wb_val = sext32(wb_sh[31:0]);
				else wb_val = wb_sh[127] ? 64'shFFFF_FFFF_8000_0000 : 64'sh0000_0000_7FFF_FFFF;
			end
			WF_RAW: wb_val = wb_sh[63:0];
			default: begin
				if ((&wb_sh[127:63]) || !(|wb_sh[127:63])) wb_val = wb_sh[63:0];
				else wb_val = wb_sh[127] ? S64_MIN : S64_MAX;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ACC) begin
			case (ctl.mode)
				ACC_ADD: acc_q <= acc_q + mul_p;
				ACC_SUB: acc_q <= acc_q - mul_p;
				default: acc_q <= mul_p;
			endcase
		end
		if (state_q == ST_WB) begin
			case (ctl.dest)
				D_Q11:  q11_q  <= wb_val;
				D_Q22:  q22_q  <= wb_val;
				D_Q33:  q33_q  <= wb_val;
				D_Q12:  q12_q  <= wb_val;
				D_Q13:  q13_q  <= wb_val;
				D_Q23:  q23_q  <= wb_val;
				D_M2:   m2_q   <= wb_val;
				D_DEN:  den_q  <= wb_val;
				D_QS1M: qs1m_q <= wb_val;
				D_QS2M: qs2m_q <= wb_val;
				D_QS3M: qs3m_q <= wb_val;
				D_VB0:  vb_q[0] <= wb_val[31:0];
				D_VB1:  vb_q[1] <= wb_val[31:0];
				D_VB2:  vb_q[2] <= wb_val[31:0];
				D_RHOE: rhoe_q <= wb_val;
				D_T1:   t1_q   <= wb_val;
				D_T2:   t2_q   <= wb_val;
				D_T3:   t3_q   <= wb_val;
				D_F0:   f_q[0] <= wb_val;
				D_F1:   f_q[1] <= wb_val;
				D_F2:   f_q[2] <= wb_val;
				D_TQ0:  tq_q[0] <= wb_val;
				D_TQ1:  tq_q[1] <= wb_val;
				D_TQ2:  tq_q[2] <= wb_val;
				default: ;   // the speed squared goes straight to the square root
			endcase
		end
	end

	//------------------------------------------------------------------
	// Rotation matrix numerators, one per division in row-major order.
	//------------------------------------------------------------------
	always_comb begin
		case (div_idx_q)
			4'd0: num_w = ((q11_q - q22_q - q33_q) <<< 2) + m2_q;
			4'd1: num_w = (q12_q <<< 3) + (qs3m_q <<< 2);
			4'd2: num_w = (q13_q <<< 3) - (qs2m_q <<< 2);
			4'd3: num_w = (q12_q <<< 3) - (qs3m_q <<< 2);
			4'd4: num_w = ((q22_q - q11_q - q33_q) <<< 2) + m2_q;
			4'd5: num_w = (q23_q <<< 3) + (qs1m_q <<< 2);
			4'd6: num_w = (q13_q <<< 3) + (qs2m_q <<< 2);
			4'd7: num_w = (q23_q <<< 3) - (qs1m_q <<< 2);
			default: num_w = ((q33_q - q11_q - q22_q) <<< 2) + m2_q;
		endcase
	end

	// Restoring division of |num| * 2^29 by den, one quotient bit a cycle.
	assign rsh_w  = {rem_q[62:0], dvd_q[DIV_BITS-1]};
	assign dsub_w = rem_q[63] || (rsh_w >= den_q);
	assign qsat_w = quo_q[63] ? S64_MAX : quo_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV_LOAD) begin
			dvd_q  <= {(num_w[63] ? 64'(-num_w) : num_w), 29'b0};
			dneg_q <= num_w[63];
			rem_q  <= '0;
			quo_q  <= '0;
		end
		if (state_q == ST_DIV_RUN) begin
			dvd_q <= {dvd_q[DIV_BITS-2:0], 1'b0};
			rem_q <= dsub_w ? rsh_w - den_q : rsh_w;
			quo_q <= {quo_q[62:0], dsub_w};
		end
		if (state_q == ST_DIV_WB) begin
			c_q[div_idx_q] <= dneg_q ? -$signed(qsat_w) : $signed(qsat_w);
		end
	end

	//------------------------------------------------------------------
	// Integer square root of the speed squared, two radicand bits a cycle.
	//------------------------------------------------------------------
	assign sbit_w = 64'd1 << {sq_k_q, 1'b0};
	assign st_w   = sres_q + sbit_w;

	always_ff @(posedge clk) begin
		if (state_q == ST_WB && step_q == STEP_PRE_SQRT) begin
			sx_q   <= wb_val;
			sres_q <= '0;
		end
		if (state_q == ST_SQRT) begin
			if (sx_q >= st_w) begin
				sx_q   <= sx_q - st_w;
				sres_q <= (sres_q >> 1) + sbit_w;
			end else begin
				sres_q <= sres_q >> 1;
			end
		end
		if (state_q == ST_CHECK) zero_q <= (sres_q == 64'd0);
		if (s_accept) zero_q <= 1'b0;
	end

	//------------------------------------------------------------------
	// Output register: zero force and torque when the speed rounds to zero.
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= zero_q ? '0 : {tq_q[2], tq_q[1], tq_q[0], f_q[2], f_q[1], f_q[0]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	`include "cannonball_drag_force_assert.svh"

	`CDF_ASSERT_NOW(a_mul_done_in_wait, mul_done, state_q == ST_MUL_WAIT, "multiplier result outside wait")
	`CDF_ASSERT_NOW(a_den_positive, state_q == ST_DIV_RUN, den_q > 64'sd0, "division by nonpositive denominator")
	`CDF_ASSERT_NOW(a_out_free, out_load, !out_valid_q || m_tready, "output register overwritten")
	`CDF_ASSERT_NEXT(a_accept_starts, s_accept, state_q == ST_MUL_ISSUE && step_q == 6'd0, "item not started")

endmodule

@@ verif/tb_cannonball_drag_force.sv @@
// Self-checking testbench for the cannonball drag force block: directed table, then random.
// Depends on cdf_pkg and the cannonball_drag_force RTL; carries its own bit-true predictor.
module tb_cannonball_drag_force;
	import cdf_pkg::*;

	localparam int N_RANDOM  = 1500;
	localparam int N_PHASES  = 6;
	localparam int MAX_SHOWN = 10;
	localparam logic signed [127:0] W_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [127:0] W_MIN = -128'sh7FFF_FFFF_FFFF_FFFF - 128'sd1;

	// One input word: MRP, velocity and wind per axis, density sample and correction.
	typedef struct packed {
		logic [2:0][31:0] mrp;
		logic [2:0][31:0] vel;
		logic [2:0][31:0] wind;
		logic [62:0]      rho;
		logic             rho_valid;
		logic [31:0]      corr;
	} sample_t;

	// One output word: body force and torque per axis.
	typedef struct packed {
		logic [2:0][63:0] frc;
		logic [2:0][63:0] trq;
	} drag_t;

	typedef struct packed {
		sample_t s;
		logic    known;
		drag_t   r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic [USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// Predictor copy of registers and held density.
	logic [15:0] cd_q;
	logic [31:0] area_q;
	logic [2:0][31:0] off_q;
	logic [62:0] density_q;

	drag_t drag_due[$];
	int n_fail = 0;
	int n_words_in = 0;
	int n_words_out = 0;
	int burst_left = 0;
	row_t dir_tab[$];

	cannonball_drag_force DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #4 clk = ~clk;

	// ---------------- fixed-point helpers of the predictor ----------------
	function automatic logic signed [63:0] sat64(input logic signed [127:0] a);
		if (a > W_MAX) return S64_MAX;
		if (a < W_MIN) return S64_MIN;
		return a[63:0];
	endfunction

	function automatic logic signed [63:0] mul_shift(input logic signed [63:0] a,
			input logic signed [63:0] b, input int n);
		logic signed [127:0] wa, wb;
		wa = a;
		wb = b;
		return sat64((wa * wb) >>> n);
	endfunction

	// Rotation-matrix entry: num * 2^29 / den, truncated toward zero.
	function automatic logic signed [63:0] dcm_div(input logic signed [63:0] num,
			input logic [63:0] den);
		logic [63:0] mag, quo;
		logic [127:0] wide;
		mag = num[63] ? -num : num;
		wide = {64'd0, mag} << 29;
		wide = wide / {64'd0, den};
		quo = wide[63:0];
		if (quo[63]) quo = S64_MAX;
		return num[63] ? -quo : quo;
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
		logic [63:0] res, bm;
		res = 0;
		bm = 64'd1 << 62;
		while (bm > x) bm = bm >> 2;
		while (bm != 0) begin
			if (x >= res + bm) begin
				x = x - (res + bm);
				res = (res >> 1) + bm;
			end else begin
				res = res >> 1;
			end
			bm = bm >> 2;
		end
		return res;
	endfunction

	// Advance the held density and compute one force/torque word.
	function automatic drag_t drag_of(input sample_t s);
		logic signed [63:0] sm [3];
		logic signed [63:0] rel [3];
		logic signed [63:0] cm [3][3];
		logic signed [63:0] vb [3];
		logic signed [63:0] fb [3];
		logic signed [63:0] ob [3];
		logic signed [63:0] q11, q22, q33, q12, q13, q23, pp, mm, dd, m2, a1, a2, a3;
		logic signed [63:0] rho_e, t1, t2, t3;
		logic signed [127:0] acc;
		logic [63:0] den, ssq, vmag;
		drag_t r;
		if (s.rho_valid) density_q = s.rho;
		for (int i = 0; i < 3; i++) begin
			sm[i] = sext32(s.mrp[i]);
			rel[i] = sext32(s.vel[i]) - sext32(s.wind[i]);
			ob[i] = sext32(off_q[i]);
		end
		q11 = mul_shift(sm[0], sm[0], 29);
		q22 = mul_shift(sm[1], sm[1], 29);
		q33 = mul_shift(sm[2], sm[2], 29);
		q12 = mul_shift(sm[0], sm[1], 29);
		q13 = mul_shift(sm[0], sm[2], 29);
		q23 = mul_shift(sm[1], sm[2], 29);
		pp = q11 + q22 + q33;
		mm = QONE - pp;
		dd = QONE + pp;
		m2 = mul_shift(mm, mm, 29);
		den = mul_shift(dd, dd, 29);
		a1 = 4 * mul_shift(sm[0], mm, 29);
		a2 = 4 * mul_shift(sm[1], mm, 29);
		a3 = 4 * mul_shift(sm[2], mm, 29);
		cm[0][0] = dcm_div(4 * (q11 - q22 - q33) + m2, den);
		cm[0][1] = dcm_div(8 * q12 + a3, den);
		cm[0][2] = dcm_div(8 * q13 - a2, den);
		cm[1][0] = dcm_div(8 * q12 - a3, den);
		cm[1][1] = dcm_div(4 * (q22 - q11 - q33) + m2, den);
		cm[1][2] = dcm_div(8 * q23 + a1, den);
		cm[2][0] = dcm_div(8 * q13 + a2, den);
		cm[2][1] = dcm_div(8 * q23 - a1, den);
		cm[2][2] = dcm_div(4 * (q33 - q11 - q22) + m2, den);
		ssq = 0;
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) acc = acc + 128'(cm[i][j]) * 128'(rel[j]);
			vb[i] = sat64(acc >>> 29);
			if (vb[i] > 64'sd2147483647) vb[i] = 64'sd2147483647;
			if (vb[i] < -64'sd2147483648) vb[i] = -64'sd2147483648;
			ssq = ssq + 64'(vb[i] * vb[i]);
		end
		vmag = floor_sqrt(ssq);
		r = '0;
		// Air speed rounds to zero: no force, no torque.
		if (vmag == 0) return r;
		rho_e = mul_shift({1'b0, density_q}, QONE30 + sext32(s.corr), 30);
		t1 = {48'd0, cd_q} * {32'd0, area_q};
		t2 = mul_shift(t1, vmag, 24);
		t3 = mul_shift(t2, rho_e, 24);
		for (int i = 0; i < 3; i++) begin
			fb[i] = mul_shift(t3, -vb[i], 32);
			r.frc[i] = fb[i];
		end
		for (int i = 0; i < 3; i++) begin
			r.trq[i] = sat64((128'(ob[(i + 1) % 3]) * 128'(fb[(i + 2) % 3])
				- 128'(ob[(i + 2) % 3]) * 128'(fb[(i + 1) % 3])) >>> 16);
		end
		return r;
	endfunction

	// ---------------- drivers ----------------
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_W'({idx, 2'b00});
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_DRAG_COEFF: cd_q = val[15:0];
			REG_AREA:       area_q = val;
			REG_OFFSET_X:   off_q[0] = val;
			REG_OFFSET_Y:   off_q[1] = val;
			REG_OFFSET_Z:   off_q[2] = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [15:0] cd, input logic [31:0] area,
			input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz);
		write_reg(REG_DRAG_COEFF, {16'd0, cd});
		write_reg(REG_AREA, area);
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_OFFSET_Y, oy);
		write_reg(REG_OFFSET_Z, oz);
	endtask

	// Drive one word at the falling edge, hold until accepted, then at times insert a burst gap.
	task automatic send_word(input sample_t s, input logic known, input drag_t r);
		drag_t due;
		@(negedge clk);
		s_tdata = {1'b0, s.corr, s.rho, s.wind[2], s.wind[1], s.wind[0],
			s.vel[2], s.vel[1], s.vel[0], s.mrp[2], s.mrp[1], s.mrp[0]};
		s_tuser = s.rho_valid;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		due = drag_of(s);
		drag_due.push_back(known ? r : due);
		n_words_in++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 7);
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				repeat ($urandom_range(0, 14)) @(negedge clk);
			end
		end
	endtask

	// Drop valid first so the idle block cannot take the last word again.
	task automatic drain;
		@(negedge clk);
		s_tvalid = 1'b0;
		while (drag_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_s32(input int mode);
		case (mode)
			0: return 32'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
			1: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
			default: return $urandom;
		endcase
	endfunction

	// Mostly well-formed attitude and speed, with a share of raw noise.
	function automatic sample_t rand_sample();
		sample_t s;
		int am, vm;
		am = $urandom_range(0, 3);
		vm = $urandom_range(0, 3);
		for (int i = 0; i < 3; i++) begin
			s.mrp[i] = rand_s32(am == 3 ? 2 : 0);
			s.vel[i] = rand_s32(vm == 3 ? 2 : 1) << (vm == 2 ? 6 : 0);
			s.wind[i] = ($urandom_range(0, 2) == 0) ? 32'd0 : rand_s32(vm == 3 ? 2 : 1);
		end
		if ($urandom_range(0, 31) == 0) s.wind = s.vel;
		s.rho = 63'(($urandom_range(0, 1) != 0) ? {$urandom, $urandom} :
			64'($urandom) << 8);
		s.rho_valid = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 2))
			0: s.corr = 32'd0;
			1: s.corr = rand_s32(1);
			default: s.corr = $urandom;
		endcase
		return s;
	endfunction

	function automatic row_t mk_row(input logic [31:0] m, input logic [31:0] v,
			input logic [31:0] w, input logic [62:0] rho, input logic vld,
			input logic [31:0] corr, input logic known);
		row_t t;
		t.s.mrp = {m, m, m};
		t.s.vel = {v, v, v};
		t.s.wind = {w, w, w};
		t.s.rho = rho;
		t.s.rho_valid = vld;
		t.s.corr = corr;
		t.known = known;
		t.r = '0;
		return t;
	endfunction

	// Receiver: ready stretches, short stalls, and now and then a stall long enough
	// for the block to finish the next word behind the held output.
	initial begin
		int k;
		forever begin
			k = $urandom_range(0, 15);
			@(negedge clk);
			m_tready = (k < 9);
			if (k == 15) repeat ($urandom_range(1000, 1600)) @(negedge clk);
			else repeat ($urandom_range(1, 20)) @(negedge clk);
		end
	end

	// Output checker: compare each accepted word, field by field, with the oldest due.
	always @(posedge clk) begin
		drag_t got, due;
		logic bad;
		if (arst_n && m_tvalid && m_tready) begin
			got.frc = {m_tdata[191:128], m_tdata[127:64], m_tdata[63:0]};
			got.trq = {m_tdata[383:320], m_tdata[319:256], m_tdata[255:192]};
			n_words_out++;
			if (drag_due.size() == 0) begin
				n_fail++;
				if (n_fail <= MAX_SHOWN) $display("unexpected output word %h", m_tdata);
			end else begin
				due = drag_due.pop_front();
				bad = 1'b0;
				for (int i = 0; i < 3; i++) begin
					if (got.frc[i] !== due.frc[i]) begin
						bad = 1'b1;
						if (n_fail < MAX_SHOWN)
							$display("word %0d force[%0d]: expected %h got %h",
								n_words_out, i, due.frc[i], got.frc[i]);
					end
					if (got.trq[i] !== due.trq[i]) begin
						bad = 1'b1;
						if (n_fail < MAX_SHOWN)
							$display("word %0d torque[%0d]: expected %h got %h",
								n_words_out, i, due.trq[i], got.trq[i]);
					end
				end
				if (bad) n_fail++;
			end
		end
	end

	initial begin
		#200_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [31:0] ox, oy, oz;
		cd_q = 0;
		area_q = 0;
		off_q = '0;
		density_q = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table. Known rows: nothing loaded yet, zero air speed, zero density.
		dir_tab.push_back(mk_row(32'h0, 32'h0064_0000, 32'h0, 63'd1 << 40, 1'b0, 32'h0, 1'b1));
		dir_tab.push_back(mk_row(32'h0, 32'h0064_0000, 32'h0, 63'd1 << 40, 1'b1, 32'h0, 1'b0));
		dir_tab.push_back(mk_row(32'h1234_5678, 32'h0010_0000, 32'h0010_0000, 63'd5, 1'b1,
			32'h0, 1'b1));
		dir_tab.push_back(mk_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 63'd1 << 50,
			1'b1, 32'h0, 1'b0));
		dir_tab.push_back(mk_row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 63'd1 << 50,
			1'b0, 32'h0, 1'b0));
		dir_tab.push_back(mk_row(32'h2000_0000, 32'h0100_0000, 32'h0, {63{1'b1}}, 1'b1,
			32'h7FFF_FFFF, 1'b0));
		dir_tab.push_back(mk_row(32'h0, 32'h0100_0000, 32'hFF00_0000, 63'd0, 1'b0,
			32'h8000_0000, 1'b0));
		dir_tab.push_back(mk_row(32'hE000_0000, 32'hFFFF_FFFF, 32'h0, 63'd0, 1'b1,
			32'h0, 1'b1));
		dir_tab.push_back(mk_row(32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 63'd1 << 62, 1'b1,
			32'hFFFF_FFFF, 1'b0));
		dir_tab.push_back(mk_row(32'h0AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 63'h2AAA_AAAA,
			1'b1, 32'h5555_5555, 1'b0));
		dir_tab.push_back(mk_row(32'hF555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 63'h5555_5555,
			1'b0, 32'hAAAA_AAAA, 1'b0));
		dir_tab.push_back(mk_row(32'h0, 32'h7FFF_FFFF, 32'h0, 63'd1 << 20, 1'b1,
			32'h8000_0000, 1'b0));

		send_word(dir_tab[0].s, dir_tab[0].known, dir_tab[0].r);
		drain();
		set_config(16'd1925, 32'd32768, 32'd6554, -32'sd3277, 32'd13107);
		for (int i = 1; i < dir_tab.size(); i++)
			send_word(dir_tab[i].s, dir_tab[i].known, dir_tab[i].r);
		drain();

		// Random phases, each under its own register setting, extremes first.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: set_config(16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
					32'h7FFF_FFFF);
				1: set_config(16'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
				2: set_config(16'd1, 32'd1, 32'd0, 32'd0, 32'd0);
				default: begin
					ox = $urandom;
					oy = $urandom;
					oz = $urandom >> $urandom_range(0, 24);
					set_config(16'($urandom), $urandom, ox, oy, oz);
				end
			endcase
			for (int i = 0; i < N_RANDOM / N_PHASES; i++) send_word(rand_sample(), 1'b0, '0);
			drain();
		end

		repeat (1400) @(posedge clk);
		$display("%0d words sent, %0d checked over %0d register settings with random stalls",
			n_words_in, n_words_out, N_PHASES + 2);
		if (n_fail == 0 && drag_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d words still due", n_fail, drag_due.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule
